[hdl/four_motor_slew_limited_drive_top_defines.svh]
// Assertion helpers used by the drive's back end.
`ifndef FOUR_MOTOR_SLEW_LIMITED_DRIVE_TOP_DEFINES_SVH
`define FOUR_MOTOR_SLEW_LIMITED_DRIVE_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define FMSD_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define FMSD_ASSERT_IMPL(label, clk_s, rst_s, pre, post, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error(msg);

`endif

[hdl/fmsd_pkg.sv]
`default_nettype none

package fmsd_pkg;

    localparam int DEFAULT_NUM_MOTORS = 4;
    localparam int MOTOR_W = 2;
    localparam int SPEED_W = 16;
    localparam int DUTY_W = 8;
    localparam int SDUTY_W = 9;
    localparam int STEP_W = 9;
    localparam int MASK_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam int MOTOR_CMP_W = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [STEP_W-1:0] MAX_STEP_RESET = 9'd16;
    localparam logic [MASK_W-1:0] INVERT_MASK_RESET = 4'd0;
    localparam logic signed [SDUTY_W-1:0] DUTY_MAX = 9'sd255;
    localparam logic signed [SDUTY_W-1:0] DUTY_MIN = -9'sd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_STEP    = 1'b0,
        REG_INVERT_MASK = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_STOP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        DIR_COAST = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_REV   = 2'd2
    } dir_t;

    // One classified request waiting for the back end.
    typedef struct packed {
        logic                      stop;
        logic [MOTOR_W-1:0]        motor;
        logic signed [SDUTY_W-1:0] target;
    } cmd_t;

    function automatic dir_t dir_of(input logic signed [SDUTY_W-1:0] d);
        dir_t r;
        if (d > 0)
        begin
            r = DIR_FWD;
        end
        else if (d < 0)
        begin
            r = DIR_REV;
        end
        else
        begin
            r = DIR_COAST;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/fmsd_front.sv]
`default_nettype none

// Accepts requests, drops set requests for motors that do not exist, and
// turns the target into a clamped signed duty, negated per invert_mask.
module fmsd_front #(
    parameter int NUM_MOTORS = fmsd_pkg::DEFAULT_NUM_MOTORS
) (
    input  wire logic                                cmd_valid,
    output logic                                     cmd_stall,
    input  wire logic                                op,
    input  wire logic [fmsd_pkg::MOTOR_W-1:0]        motor,
    input  wire logic signed [fmsd_pkg::SPEED_W-1:0] target_speed,
    input  wire logic [fmsd_pkg::MASK_W-1:0]         invert_mask,
    input  wire logic                                q_full,
    output logic                                     push,
    output fmsd_pkg::cmd_t                           push_cmd
);

    logic                                  is_stop;
    logic                                  in_range;
    logic signed [fmsd_pkg::SPEED_W:0]     wide_target;
    logic signed [fmsd_pkg::SPEED_W:0]     signed_target;
    logic signed [fmsd_pkg::SDUTY_W-1:0]   clamped;

    assign cmd_stall = q_full;
    assign is_stop = (op == fmsd_pkg::OP_STOP);
    assign in_range = (fmsd_pkg::MOTOR_CMP_W'(motor) < fmsd_pkg::MOTOR_CMP_W'(NUM_MOTORS));

    always_comb
    begin
        wide_target = (fmsd_pkg::SPEED_W + 1)'(target_speed);
        signed_target = invert_mask[motor] ? -wide_target : wide_target;
        if (signed_target > (fmsd_pkg::SPEED_W + 1)'(fmsd_pkg::DUTY_MAX))
        begin
            clamped = fmsd_pkg::DUTY_MAX;
        end
        else if (signed_target < (fmsd_pkg::SPEED_W + 1)'(fmsd_pkg::DUTY_MIN))
        begin
            clamped = fmsd_pkg::DUTY_MIN;
        end
        else
        begin
            clamped = signed_target[fmsd_pkg::SDUTY_W-1:0];
        end
    end

    assign push = cmd_valid && !cmd_stall && (is_stop || in_range);

    always_comb
    begin
        push_cmd.stop = is_stop;
        push_cmd.motor = motor;
        push_cmd.target = clamped;
    end

endmodule

`default_nettype wire

[hdl/fmsd_queue.sv]
`default_nettype none

// Short request queue between the front and back ends.
module fmsd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire fmsd_pkg::cmd_t  push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output fmsd_pkg::cmd_t       head_cmd
);

    localparam int PTR_W = (fmsd_pkg::QUEUE_DEPTH > 1) ? $clog2(fmsd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(fmsd_pkg::QUEUE_DEPTH + 1);

    fmsd_pkg::cmd_t    entry_reg [fmsd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full = (count_reg == CNT_W'(fmsd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fmsd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fmsd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hdl/fmsd_back.sv]
`default_nettype none

`include "four_motor_slew_limited_drive_top_defines.svh"

// Applies the slew limit against the stored duty of each motor, steps a
// stop request through all motors, and holds results in an output register.
module fmsd_back #(
    parameter int NUM_MOTORS = fmsd_pkg::DEFAULT_NUM_MOTORS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [fmsd_pkg::STEP_W-1:0]      max_step,
    input  wire logic                             q_valid,
    input  wire fmsd_pkg::cmd_t                   q_cmd,
    output logic                                  pop,
    output logic                                  res_valid,
    input  wire logic                             res_stall,
    output logic [fmsd_pkg::MOTOR_W-1:0]          motor_out,
    output logic [fmsd_pkg::DUTY_W-1:0]           duty,
    output logic [1:0]                            direction,
    output logic                                  direction_changed,
    output logic                                  last
);

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int ACC_W = fmsd_pkg::SDUTY_W + 2;

    logic signed [fmsd_pkg::SDUTY_W-1:0] duty_reg [NUM_MOTORS];
    logic [IDX_W-1:0]                    step_cnt_reg;
    logic [IDX_W-1:0]                    step_cnt_next;
    logic                                res_valid_reg;
    logic                                res_valid_next;
    logic [fmsd_pkg::MOTOR_W-1:0]        res_motor_reg;
    logic [fmsd_pkg::DUTY_W-1:0]         res_duty_reg;
    fmsd_pkg::dir_t                      res_dir_reg;
    logic                                res_changed_reg;
    logic                                res_last_reg;

    logic                                advance;
    logic                                fire;
    logic                                item_last;
    logic [IDX_W-1:0]                    idx;
    logic signed [fmsd_pkg::SDUTY_W-1:0] prev;
    logic signed [ACC_W-1:0]             prev_w;
    logic signed [ACC_W-1:0]             target_w;
    logic signed [ACC_W-1:0]             step_w;
    logic signed [ACC_W-1:0]             delta;
    logic signed [ACC_W-1:0]             limited;
    logic signed [fmsd_pkg::SDUTY_W-1:0] new_duty;
    logic [fmsd_pkg::SDUTY_W-1:0]        new_mag;
    fmsd_pkg::dir_t                      new_dir;

    assign advance = !res_valid_reg || !res_stall;
    assign fire = advance && q_valid;
    assign item_last = !q_cmd.stop || (step_cnt_reg == IDX_W'(NUM_MOTORS - 1));
    assign pop = fire && item_last;
    assign idx = q_cmd.stop ? step_cnt_reg : IDX_W'(q_cmd.motor);
    assign prev = duty_reg[idx];

    // Move toward the target by at most the configured step.
    always_comb
    begin
        prev_w = ACC_W'(prev);
        target_w = ACC_W'(q_cmd.target);
        step_w = signed'(ACC_W'(max_step));
        delta = target_w - prev_w;
        if (delta > step_w)
        begin
            limited = prev_w + step_w;
        end
        else if (delta < -step_w)
        begin
            limited = prev_w - step_w;
        end
        else
        begin
            limited = target_w;
        end
        new_duty = q_cmd.stop ? '0 : limited[fmsd_pkg::SDUTY_W-1:0];
        new_mag = (new_duty < 0) ? -new_duty : new_duty;
        new_dir = fmsd_pkg::dir_of(new_duty);
    end

    always_comb
    begin
        step_cnt_next = step_cnt_reg;
        if (fire && q_cmd.stop)
        begin
            step_cnt_next = item_last ? '0 : step_cnt_reg + 1'b1;
        end
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                duty_reg[i] <= '0;
            end
        end
        else
        begin
            step_cnt_reg <= step_cnt_next;
            res_valid_reg <= res_valid_next;
            if (fire)
            begin
                duty_reg[idx] <= new_duty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_motor_reg <= fmsd_pkg::MOTOR_W'(idx);
            res_duty_reg <= new_mag[fmsd_pkg::DUTY_W-1:0];
            res_dir_reg <= new_dir;
            res_changed_reg <= (new_dir != fmsd_pkg::dir_of(prev));
            res_last_reg <= item_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign motor_out = res_motor_reg;
    assign duty = res_duty_reg;
    assign direction = res_dir_reg;
    assign direction_changed = res_changed_reg;
    assign last = res_last_reg;

    `FMSD_ASSERT_IMPL(a_stop_head_held, clk, rst_n, res_valid_reg && !res_last_reg,
                      q_valid && q_cmd.stop, "non-final result without a stop at the head")
    `FMSD_ASSERT_IMPL(a_cnt_only_in_stop, clk, rst_n, step_cnt_reg != '0,
                      q_valid && q_cmd.stop, "motor counter running outside a stop")
    `FMSD_ASSERT(a_coast_iff_zero, clk, rst_n,
                 !res_valid_reg || ((res_duty_reg == '0) == (res_dir_reg == fmsd_pkg::DIR_COAST)),
                 "direction disagrees with duty")

endmodule

`default_nettype wire

[hdl/four_motor_slew_limited_drive_top.sv]
`default_nettype none

// Slew-limited drive for a set of H-bridge motors. A set-speed request names
// a motor and a signed target; the target is negated when the motor's bit in
// invert_mask is set, clamped to -255..255, and the motor's stored duty moves
// toward it by at most max_step. Each result gives the duty magnitude, the
// bridge direction (0 coast, 1 forward, 2 reverse), whether the direction
// changed from the previous result for that motor, and a last flag. A stop
// request zeroes every motor, without the ramp, one motor at a time, and
// gives one result per motor in motor order with the final one marked. A set
// request for a motor index at or above NUM_MOTORS is accepted and dropped
// with no result. Set requests flow at one per cycle while the results do
// not stall; a stop request holds the back end for one result per motor,
// one per cycle while not stalled, which is what bounds the rate here. A
// two-entry request queue sits between the front end and the back end, so
// requests keep being taken while results wait; each request is registered
// in the queue and then in the result register. Configuration writes are
// always ready and should be made only while the block is idle.
module four_motor_slew_limited_drive_top #(
    parameter int NUM_MOTORS = fmsd_pkg::DEFAULT_NUM_MOTORS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Request channel.
    input  wire logic                                cmd_valid,
    output logic                                     cmd_stall,
    input  wire logic                                op,
    input  wire logic [fmsd_pkg::MOTOR_W-1:0]        motor,
    input  wire logic signed [fmsd_pkg::SPEED_W-1:0] target_speed,
    // Result channel.
    output logic                                     res_valid,
    input  wire logic                                res_stall,
    output logic [fmsd_pkg::MOTOR_W-1:0]             motor_out,
    output logic [fmsd_pkg::DUTY_W-1:0]              duty,
    output logic [1:0]                               direction,
    output logic                                     direction_changed,
    output logic                                     last,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fmsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fmsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [fmsd_pkg::STEP_W-1:0] max_step_reg;
    logic [fmsd_pkg::MASK_W-1:0] invert_mask_reg;
    logic                        cfg_write;
    logic                        q_push;
    fmsd_pkg::cmd_t              q_push_cmd;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_valid;
    fmsd_pkg::cmd_t              q_head;

    // The register file never pushes back.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg <= fmsd_pkg::MAX_STEP_RESET;
            invert_mask_reg <= fmsd_pkg::INVERT_MASK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fmsd_pkg::REG_MAX_STEP:
                begin
                    max_step_reg <= cfg_data[fmsd_pkg::STEP_W-1:0];
                end
                fmsd_pkg::REG_INVERT_MASK:
                begin
                    invert_mask_reg <= cfg_data[fmsd_pkg::MASK_W-1:0];
                end
                default:
                begin
                    max_step_reg <= max_step_reg;
                end
            endcase
        end
    end

    // The front end classifies each request and shapes the target before
    // it enters the queue.
    fmsd_front #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_front (
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .op           (op),
        .motor        (motor),
        .target_speed (target_speed),
        .invert_mask  (invert_mask_reg),
        .q_full       (q_full),
        .push         (q_push),
        .push_cmd     (q_push_cmd)
    );

    fmsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // The back end owns the per-motor duty state and the result register.
    fmsd_back #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_step          (max_step_reg),
        .q_valid           (q_valid),
        .q_cmd             (q_head),
        .pop               (q_pop),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .motor_out         (motor_out),
        .duty              (duty),
        .direction         (direction),
        .direction_changed (direction_changed),
        .last              (last)
    );

endmodule

`default_nettype wire

[verif/tb_four_motor_slew_limited_drive_top.sv]
`timescale 1ns / 1ps

module tb_four_motor_slew_limited_drive_top;

    import fmsd_pkg::*;

    localparam int MOTORS = DEFAULT_NUM_MOTORS;
    // This limit only catches a hung block.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles allowed after the last result before the block is treated as idle.
    localparam int SETTLE_CYCLES = 8;

    logic                       clk;
    logic                       rst_n;
    logic                       cmd_valid;
    logic                       cmd_stall;
    logic                       op;
    logic [MOTOR_W-1:0]         motor;
    logic signed [SPEED_W-1:0]  target_speed;
    logic                       res_valid;
    logic                       res_stall = 1'b0;
    logic [MOTOR_W-1:0]         motor_out;
    logic [DUTY_W-1:0]          duty;
    logic [1:0]                 direction;
    logic                       direction_changed;
    logic                       last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // Percent chance per cycle that the request side holds back or the result
    // side stalls. The main sequence changes these between phases.
    int send_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    // Tracks the signed duty and bridge state of every motor, predicts the
    // results of each accepted request and checks the results in order.
    class slew_drive_tracker;
        typedef struct {
            logic [MOTOR_W-1:0] motor_id;
            logic [DUTY_W-1:0]  magnitude;
            dir_t               bridge;
            logic               flipped;
            logic               is_last;
        } drive_result_t;

        logic [STEP_W-1:0] step_limit = MAX_STEP_RESET;
        logic [MASK_W-1:0] invert_bits = INVERT_MASK_RESET;
        int                signed_duty [MOTORS];
        dir_t              bridge_seen [MOTORS] = '{default: DIR_COAST};
        drive_result_t     pending [$];
        int                mismatches = 0;
        int                checked = 0;
        int                requests = 0;
        int                stops = 0;
        int                reg_writes = 0;

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                REG_MAX_STEP:    step_limit = data[STEP_W-1:0];
                REG_INVERT_MASK: invert_bits = data[MASK_W-1:0];
                default:         ;
            endcase
        endfunction

        function void record(int m, int d, bit fin);
            drive_result_t r;
            r.motor_id = MOTOR_W'(m);
            r.magnitude = DUTY_W'((d < 0) ? -d : d);
            if (d > 0)
            begin
                r.bridge = DIR_FWD;
            end
            else if (d < 0)
            begin
                r.bridge = DIR_REV;
            end
            else
            begin
                r.bridge = DIR_COAST;
            end
            r.flipped = (r.bridge != bridge_seen[m]);
            r.is_last = fin;
            signed_duty[m] = d;
            bridge_seen[m] = r.bridge;
            pending.push_back(r);
        endfunction

        function void take_request(op_t kind, logic [MOTOR_W-1:0] m,
                                   logic signed [SPEED_W-1:0] speed);
            int want;
            int prev;
            int nxt_duty;
            requests++;
            if (kind == OP_STOP)
            begin
                stops++;
                for (int i = 0; i < MOTORS; i++)
                begin
                    record(i, 0, i == MOTORS - 1);
                end
            end
            else if (m < MOTORS)
            begin
                want = int'(speed);
                if (invert_bits[m])
                begin
                    want = -want;
                end
                if (want > 255)
                begin
                    want = 255;
                end
                if (want < -255)
                begin
                    want = -255;
                end
                prev = signed_duty[m];
                nxt_duty = want;
                if (want - prev > int'(step_limit))
                begin
                    nxt_duty = prev + int'(step_limit);
                end
                else if (want - prev < -int'(step_limit))
                begin
                    nxt_duty = prev - int'(step_limit);
                end
                record(m, nxt_duty, 1'b1);
            end
        endfunction

        function void compare_field(string label, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            end
        endfunction

        function void check_output(logic [MOTOR_W-1:0] m, logic [DUTY_W-1:0] mag,
                                   logic [1:0] dir, logic chg, logic fin);
            drive_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual motor %0d duty %0d",
                         $time, m, mag);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            compare_field("motor_out", 16'(exp_r.motor_id), 16'(m));
            compare_field("duty", 16'(exp_r.magnitude), 16'(mag));
            compare_field("direction", 16'(exp_r.bridge), 16'(dir));
            compare_field("direction_changed", 16'(exp_r.flipped), 16'(chg));
            compare_field("last", 16'(exp_r.is_last), 16'(fin));
        endfunction
    endclass

    slew_drive_tracker tracker;

    four_motor_slew_limited_drive_top u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // All three channels are observed at the clock edge, before any of the
    // nonblocking updates of that edge land, so the values seen here are the
    // ones the block saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                tracker.take_request(op_t'(op), motor, target_speed);
            end
            if (res_valid && !res_stall)
            begin
                tracker.check_output(motor_out, duty, direction, direction_changed, last);
            end
            if (cfg_valid && cfg_ready)
            begin
                tracker.write_reg(cfg_reg_t'(cfg_index), cfg_data);
            end
        end
    end

    // The result side stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles with %0d results outstanding.",
                     cycle_count, tracker.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one request after a random number of idle cycles and holds it
    // until the block takes it. Valid is left high on return, so the next
    // call either keeps it high with a new payload or drops it to idle; valid
    // is never written twice at one edge.
    task automatic send_request(op_t kind, logic [MOTOR_W-1:0] m,
                                logic signed [SPEED_W-1:0] speed);
        while ($urandom_range(99) < send_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        op <= kind;
        motor <= m;
        target_speed <= speed;
        do
        begin
            @(posedge clk);
        end
        while (cmd_stall);
    endtask

    // Stops offering requests and waits until every predicted result has been
    // seen, then waits out SETTLE_CYCLES so that the block is known to be idle.
    task automatic settle_outputs();
        cmd_valid <= 1'b0;
        repeat (3) @(posedge clk);
        while (tracker.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes are only made while the block is idle. Valid is dropped
    // after each write is taken, before the next one is offered, so that back-to-back writes never collide.
    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Half the targets sit near the clamp range where the ramp matters; the rest
    // are full 16-bit values and corners: extremes, clamp edges, -1 and 0.
    function automatic logic signed [SPEED_W-1:0] pick_speed();
        logic signed [SPEED_W-1:0] s;
        case ($urandom_range(3))
            0, 1: s = SPEED_W'(int'($urandom_range(600)) - 300);
            2:    s = SPEED_W'($urandom);
            default:
            begin
                case ($urandom_range(7))
                    0: s = 16'sh8000;
                    1: s = 16'sh7FFF;
                    2: s = 16'sd255;
                    3: s = -16'sd255;
                    4: s = 16'sd256;
                    5: s = -16'sd256;
                    6: s = -16'sd1;
                    default: s = 16'sd0;
                endcase
            end
        endcase
        return s;
    endfunction

    // One phase of random traffic. Halfway through, the request side holds
    // off until every outstanding result has come back, so that the block
    // also restarts from an empty pipeline with its state carried over.
    task automatic run_random_phase(int count, int s_pct, int r_pct);
        send_pct = s_pct;
        stall_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                settle_outputs();
            end
            if ($urandom_range(99) < 10)
            begin
                send_request(OP_STOP, MOTOR_W'($urandom_range(3)), SPEED_W'($urandom));
            end
            else
            begin
                send_request(OP_SET, MOTOR_W'($urandom_range(3)), pick_speed());
            end
        end
        settle_outputs();
    endtask

    initial
    begin
        tracker = new;
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        op <= OP_SET;
        motor <= '0;
        target_speed <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MAX_STEP;
        cfg_data <= '0;
        send_pct = 31;
        stall_pct = 58;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a step of 16 and no inverted motors. Full-scale
        // targets of both signs ramp by one step, the most negative target
        // pulls a motor back to zero and coast, and a stop request
        // follows with motors in every bridge state.
        send_request(OP_SET, 2'd0, 16'sh7FFF);
        send_request(OP_SET, 2'd0, 16'sh8000);
        send_request(OP_SET, 2'd1, -16'sd255);
        send_request(OP_SET, 2'd2, 16'sd256);
        send_request(OP_SET, 2'd3, -16'sd1);
        send_request(OP_STOP, 2'd2, 16'sd0);
        send_request(OP_SET, 2'd0, 16'sd0);
        settle_outputs();

        // The largest step lets a motor jump straight across the whole range.
        // Every motor is inverted, so the most negative target becomes +32768
        // and must clamp to full forward. Writing all nine data bits also
        // shows that only the low four bits reach the mask.
        write_register(REG_MAX_STEP, 9'd511);
        write_register(REG_INVERT_MASK, 9'h1FF);
        send_request(OP_SET, 2'd2, 16'sh8000);
        send_request(OP_SET, 2'd3, 16'sh7FFF);
        send_request(OP_SET, 2'd3, 16'sh8000);
        send_request(OP_SET, 2'd1, 16'sd255);
        send_request(OP_SET, 2'd0, -16'sd255);
        settle_outputs();

        // A step of zero holds every motor where it is, while the results keep
        // reporting the held duty. Mask bits above the register width are
        // dropped, so this write clears the mask. A stop still zeroes every
        // motor, since it bypasses the ramp, and the motors then stay at zero.
        write_register(REG_MAX_STEP, 9'd0);
        write_register(REG_INVERT_MASK, 9'h1F0);
        send_request(OP_SET, 2'd0, -16'sd300);
        send_request(OP_SET, 2'd1, 16'sd0);
        send_request(OP_STOP, 2'd1, -16'sd1);
        send_request(OP_SET, 2'd2, 16'sd5);
        settle_outputs();

        // Random phases: first the request side idles less than the result
        // side stalls, then the reverse, then full rate on both sides. Each
        // phase starts with a fresh write of the step size and the inversion pattern.
        write_register(REG_MAX_STEP, CFG_DATA_W'($urandom_range(510, 1)));
        write_register(REG_INVERT_MASK, CFG_DATA_W'($urandom));
        run_random_phase(35, 31, 58);

        write_register(REG_MAX_STEP, 9'd1);
        write_register(REG_INVERT_MASK, CFG_DATA_W'($urandom));
        run_random_phase(35, 58, 31);

        write_register(REG_MAX_STEP, 9'd510);
        write_register(REG_INVERT_MASK, 9'd0);
        run_random_phase(35, 0, 0);

        $display("Covered %0d requests (%0d stop-all) and %0d results, over %0d register",
                 tracker.requests, tracker.stops, tracker.checked, tracker.reg_writes);
        $display("writes with steps of 0, 1, 510 and 511 and inversion patterns from none to all.");
        if (tracker.pending.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived.", $time, tracker.pending.size());
        end
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
